// ----- sv/col_pkg.sv -----
// Package for the C operator lexer: scan modes, result kinds, the result record
// and the byte classification functions.
// No dependencies.
package col_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int FIELD_BITS      = 16;
  localparam int MAX_RESULTS     = 3;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RUN,
    MODE_HOLD,
    MODE_DROP
  } mode_t;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] length;
    logic                  last;
  } res_t;

  function automatic res_t mk_res(kind_t kind, logic [FIELD_BITS-1:0] start,
                                  logic [FIELD_BITS-1:0] length);
    res_t r;
    r.kind   = kind;
    r.start  = start;
    r.length = length;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_single(logic [7:0] c);
    return c == "=" || c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
           c == "!" || c == "^" || c == "<" || c == ">" || c == "," || c == ";" ||
           c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}";
  endfunction

  function automatic logic may_pair(logic [7:0] c);
    return c == "<" || c == ">" || c == "=" || c == "!" || c == "&" || c == "|";
  endfunction

  function automatic logic is_pair(logic [7:0] a, logic [7:0] b);
    logic ok;
    ok = 1'b0;
    if (a == "<") begin
      ok = (b == "=") || (b == "<");
    end else if (a == ">") begin
      ok = (b == "=") || (b == ">");
    end else if (a == "=" || a == "!") begin
      ok = (b == "=");
    end else if (a == "&" || a == "|") begin
      ok = (b == a);
    end
    return ok;
  endfunction

endpackage

// ----- sv/c_operator_lexer_unit.sv -----
// Top level of the C operator lexer: per-byte scanner state and a small result queue.
// Depends on col_pkg.
//
// Latency: the results of an accepted byte are offered from the next cycle on.
// Throughput: one byte per cycle while each byte gives at most one result and out_ready
// stays high; a byte that gives more results holds input until at most one entry is left. Input
// ready is taken from the four-entry result queue (room for a full three-result burst).
// Reset: scanner goes idle at offset zero and the result queue empties.
module c_operator_lexer_unit #(
  parameter int OFFSET_BITS = col_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  localparam int AW = col_pkg::QUEUE_AW;
  localparam logic [OFFSET_BITS-1:0] POS_MAX  = '1;
  localparam logic [OFFSET_BITS-1:0] POS_STEP = OFFSET_BITS'(1);

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] run_start_r, run_start_nxt;
  logic [7:0]             pend_r, pend_nxt;
  col_pkg::mode_t         mode_r, mode_nxt;

  col_pkg::res_t res_c [col_pkg::MAX_RESULTS];
  logic [1:0]    n_res;
  logic          fin;
  logic          done;

  col_pkg::res_t q_r [col_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          in_xfer, out_xfer;
  logic [1:0]    n_push;

  assign in_ready  = (cnt_r <= (AW+1)'(1));
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_xfer  = out_valid && out_ready;
  assign n_push    = in_xfer ? n_res : 2'd0;

  // Scanner: mirrors the byte step, at most three results per byte.
  always_comb begin
    for (int i = 0; i < col_pkg::MAX_RESULTS; i++) begin
      res_c[i] = col_pkg::mk_res(col_pkg::KIND_TOKEN, '0, '0);
    end
    n_res         = 2'd0;
    done          = 1'b0;
    pos_nxt       = pos_r;
    run_start_nxt = run_start_r;
    pend_nxt      = pend_r;
    mode_nxt      = mode_r;
    fin           = (in_char_code == 8'd0) || in_end_of_buffer;

    if (in_char_code != 8'd0 && mode_nxt != col_pkg::MODE_DROP) begin
      if (pos_nxt == POS_MAX) begin
        res_c[n_res] = col_pkg::mk_res(col_pkg::KIND_ERROR, 16'(POS_MAX), '0);
        n_res        = n_res + 2'd1;
        mode_nxt     = col_pkg::MODE_DROP;
      end else begin
        if (mode_nxt == col_pkg::MODE_HOLD) begin
          if (col_pkg::is_pair(pend_nxt, in_char_code)) begin
            res_c[n_res] = col_pkg::mk_res(col_pkg::KIND_TOKEN, 16'(run_start_nxt), 16'd2);
            n_res        = n_res + 2'd1;
            mode_nxt     = col_pkg::MODE_IDLE;
            pos_nxt      = pos_nxt + POS_STEP;
            done         = 1'b1;
          end else if (!col_pkg::is_single(pend_nxt)) begin
            // A lone ampersand or bar is an error at its own offset.
            res_c[n_res] = col_pkg::mk_res(col_pkg::KIND_ERROR, 16'(run_start_nxt), '0);
            n_res        = n_res + 2'd1;
            mode_nxt     = col_pkg::MODE_DROP;
            done         = 1'b1;
          end else begin
            res_c[n_res] = col_pkg::mk_res(col_pkg::KIND_TOKEN, 16'(run_start_nxt), 16'd1);
            n_res        = n_res + 2'd1;
            mode_nxt     = col_pkg::MODE_IDLE;
          end
        end else if (mode_nxt == col_pkg::MODE_RUN) begin
          if (col_pkg::is_word(in_char_code)) begin
            pos_nxt = pos_nxt + POS_STEP;
            done    = 1'b1;
          end else begin
            res_c[n_res] = col_pkg::mk_res(col_pkg::KIND_TOKEN, 16'(run_start_nxt),
                                           16'(pos_nxt - run_start_nxt));
            n_res        = n_res + 2'd1;
            mode_nxt     = col_pkg::MODE_IDLE;
          end
        end

        if (!done) begin
          if (col_pkg::is_space(in_char_code)) begin
            pos_nxt = pos_nxt + POS_STEP;
          end else if (col_pkg::is_word(in_char_code)) begin
            mode_nxt      = col_pkg::MODE_RUN;
            run_start_nxt = pos_nxt;
            pos_nxt       = pos_nxt + POS_STEP;
          end else if (col_pkg::may_pair(in_char_code)) begin
            mode_nxt      = col_pkg::MODE_HOLD;
            pend_nxt      = in_char_code;
            run_start_nxt = pos_nxt;
            pos_nxt       = pos_nxt + POS_STEP;
          end else if (col_pkg::is_single(in_char_code)) begin
            res_c[n_res] = col_pkg::mk_res(col_pkg::KIND_TOKEN, 16'(pos_nxt), 16'd1);
            n_res        = n_res + 2'd1;
            pos_nxt      = pos_nxt + POS_STEP;
          end else begin
            res_c[n_res] = col_pkg::mk_res(col_pkg::KIND_ERROR, 16'(pos_nxt), '0);
            n_res        = n_res + 2'd1;
            mode_nxt     = col_pkg::MODE_DROP;
          end
        end
      end
    end

    // End of buffer or NUL byte: flush what is still open, then the end marker unless dropping after an error.
    if (fin) begin
      if (mode_nxt == col_pkg::MODE_RUN) begin
        res_c[n_res] = col_pkg::mk_res(col_pkg::KIND_TOKEN, 16'(run_start_nxt),
                                       16'(pos_nxt - run_start_nxt));
        n_res        = n_res + 2'd1;
      end else if (mode_nxt == col_pkg::MODE_HOLD) begin
        if (col_pkg::is_single(pend_nxt)) begin
          res_c[n_res] = col_pkg::mk_res(col_pkg::KIND_TOKEN, 16'(run_start_nxt), 16'd1);
        end else begin
          res_c[n_res] = col_pkg::mk_res(col_pkg::KIND_ERROR, 16'(run_start_nxt), '0);
          mode_nxt     = col_pkg::MODE_DROP;
        end
        n_res = n_res + 2'd1;
      end
      if (mode_nxt != col_pkg::MODE_DROP) begin
        res_c[n_res] = col_pkg::mk_res(col_pkg::KIND_END, '0, '0);
        n_res        = n_res + 2'd1;
      end
      pos_nxt       = '0;
      run_start_nxt = '0;
      pend_nxt      = '0;
      mode_nxt      = col_pkg::MODE_IDLE;
    end

    if (n_res != 2'd0) begin
      res_c[n_res - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      run_start_r <= '0;
      pend_r      <= '0;
      mode_r      <= col_pkg::MODE_IDLE;
    end else if (in_xfer) begin
      pos_r       <= pos_nxt;
      run_start_r <= run_start_nxt;
      pend_r      <= pend_nxt;
      mode_r      <= mode_nxt;
    end
  end

  // Result queue: up to three writes per transfer, one read per cycle while out_ready is high.
  always_ff @(posedge clk) begin
    for (int i = 0; i < col_pkg::MAX_RESULTS; i++) begin
      if (2'(i) < n_push) begin
        q_r[AW'(wr_ptr_r + AW'(i))] <= res_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(n_push);
      rd_ptr_r <= rd_ptr_r + AW'(out_xfer);
      cnt_r    <= cnt_r + (AW+1)'(n_push) - (AW+1)'(out_xfer);
    end
  end

  assign out_result_kind  = q_r[rd_ptr_r].kind;
  assign out_token_start  = q_r[rd_ptr_r].start;
  assign out_token_length = q_r[rd_ptr_r].length;
  assign out_last_of_run  = q_r[rd_ptr_r].last;

endmodule
